FILE: rtl/core/pbeq_pkg.sv
// ----------------------------------------------------------------------------
// pbeq_pkg
// Shared constants, types and helper functions of the peaking biquad EQ.
// ----------------------------------------------------------------------------
package pbeq_pkg;

   localparam int NUM_BANDS_DEF = 7;
   localparam int SAMPLE_BITS   = 24;
   localparam int COEFF_BITS    = 32;
   localparam int NUM_TAPS      = 5;
   localparam int SFRAC         = SAMPLE_BITS - 1;
   localparam int CFRAC         = COEFF_BITS - 4;
   localparam int IFRAC         = SFRAC - 5;
   localparam int XW            = SFRAC + 6;       // Q5.23 working width
   localparam int ROM_LEN       = 257;
   localparam int BAND_W        = 5;               // holds band counts up to 31
   localparam int TAP_W         = 3;
   localparam int GAIN_BITS     = 16;
   localparam int CSR_DW        = 16;
   localparam int ACC_W         = 64;
   localparam logic [XW-1:0] KNEE = XW'((95 * (64'd1 << SFRAC)) / 100);

   // action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_COEFF  = 1'b1;

   // register indexes
   localparam logic CSR_PREAMP      = 1'b0;
   localparam logic CSR_BAND_ACTIVE = 1'b1;

   // tap codes
   localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
   localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
   localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
   localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
   localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;
   localparam logic [TAP_W-1:0] TAP_LAST_DRAIN = 3'd6;

   typedef struct packed {
      logic              capture;
      logic              coef_wr;
      logic              pre_mul;
      logic              pre_sat;
      logic              acc_clear;
      logic              mac_issue;
      logic [TAP_W-1:0]  tap;
      logic [BAND_W-1:0] band;
      logic              hist_upd;
      logic              clip1;
      logic              clip2;
      logic              out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic band_on;
      logic out_free;
   } dp_status_type;

   typedef logic [ROM_LEN-1:0][SFRAC-1:0] clip_rom_type;

   // saturate a wide value to Q5.23
   function automatic logic signed [XW-1:0] sat_x(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (XW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return XW'(hi);
      end else if (v < lo) begin
         return XW'(lo);
      end
      return XW'(v);
   endfunction

   // 1-exp(-3i/32) table, evaluated at elaboration only
   function automatic clip_rom_type build_clip_rom();
      clip_rom_type rom;
      logic [127:0] y;
      logic [127:0] n;
      logic [127:0] r;
      logic [127:0] term;
      logic [127:0] sum;
      logic [127:0] v;
      logic [127:0] c;
      logic [127:0] maxv;
      maxv = (128'd1 << SFRAC) - 1;
      for (int i = 0; i < ROM_LEN; i++) begin
         y    = 128'(3 * i) << 27;
         n    = y >> 32;
         r    = y & 128'hFFFF_FFFF;
         term = 128'd1 << 32;
         sum  = 128'd1 << 32;
         for (int k = 1; k <= 14; k++) begin
            term = ((term * r) >> 32) / 128'(k);
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         v = sum;
         if (v > (128'd1 << 32)) begin
            v = 128'd1 << 32;
         end
         for (int j = 0; j < 32; j++) begin
            if (128'(j) < n) begin
               v = (v * 128'd1580030169) >> 32;
            end
         end
         c = ((128'd1 << 32) - v + (128'd1 << (31 - SFRAC))) >> (32 - SFRAC);
         rom[i] = SFRAC'((c > maxv) ? maxv : c);
      end
      return rom;
   endfunction

   localparam clip_rom_type CLIP_ROM = build_clip_rom();

endpackage

FILE: rtl/core/pbeq_if.sv
// ----------------------------------------------------------------------------
// pbeq_if
// Valid/ready stream interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface pbeq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic signed [pbeq_pkg::SAMPLE_BITS-1:0] sample_in;
   logic [2:0]                           band_index;
   logic [2:0]                           coeff_index;
   logic signed [pbeq_pkg::COEFF_BITS-1:0]  coeff_value;

   modport source (output valid, action, sample_in, band_index, coeff_index,
                   coeff_value, input ready);
   modport sink   (input valid, action, sample_in, band_index, coeff_index,
                   coeff_value, output ready);
endinterface

interface pbeq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pbeq_pkg::SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

FILE: rtl/core/peaking_biquad_eq_cascade.sv
// ----------------------------------------------------------------------------
// peaking_biquad_eq_cascade
// Preamp, cascade of peaking biquad sections and soft clipper.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. A coefficient write is taken in the
// idle state and leaves the request port open. An audio beat is preamped,
// saturated, run through the bands in order and soft-clipped, and the request
// port opens again once its result is loaded, so no audio beat is taken before
// the last is through. Each active band is a pass of five multiply-accumulates
// through one shared 32x29 multiplier fed by a coefficient memory with
// separate read and write ports, plus fill, drain and history write-back. The
// result waits in an output register, so a new beat is taken while it is still
// pending. History clears on reset through per-band valid bits.
// ----------------------------------------------------------------------------
module peaking_biquad_eq_cascade #(
   parameter int NUM_BANDS = pbeq_pkg::NUM_BANDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   pbeq_req_if.sink                     req_chan,
   pbeq_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [pbeq_pkg::CSR_DW-1:0]  csr_wdata
);
   import pbeq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pbeq_ctrl #(.NUM_BANDS(NUM_BANDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   pbeq_datapath #(.NUM_BANDS(NUM_BANDS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample_in   (req_chan.sample_in),
      .req_band_index  (req_chan.band_index),
      .req_coeff_index (req_chan.coeff_index),
      .req_coeff_value (req_chan.coeff_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_sample_out  (rsp_chan.sample_out)
   );

`ifndef NO_ASSERTIONS
   a_coef_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == ACT_COEFF)
      |=> !$rose(rsp_chan.valid))
      else $error("coefficient write produced a response beat");

   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_upd |-> ($past(cmd.mac_issue, 3) && !$past(cmd.mac_issue, 1)))
      else $error("history update before MAC pipeline drained");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_chan.valid && !req_chan.valid) || rsp_chan.valid)
      else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/core/pbeq_ctrl.sv
// ----------------------------------------------------------------------------
// pbeq_ctrl
// Sequencer: preamp, per-band MAC passes, soft clip and output load.
// ----------------------------------------------------------------------------
module pbeq_ctrl #(
   parameter int NUM_BANDS = pbeq_pkg::NUM_BANDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  pbeq_pkg::dp_status_type status,
   output pbeq_pkg::ctrl_cmd_type  cmd
);
   import pbeq_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRE   = 4'd1;
   localparam logic [3:0] S_SAT   = 4'd2;
   localparam logic [3:0] S_BAND  = 4'd3;
   localparam logic [3:0] S_MAC   = 4'd4;
   localparam logic [3:0] S_UPD   = 4'd5;
   localparam logic [3:0] S_CLIP1 = 4'd6;
   localparam logic [3:0] S_CLIP2 = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [TAP_W-1:0]  tap_ff, tap_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      tap_in   = tap_ff;
      cmd      = '0;
      cmd.band = band_ff;
      cmd.tap  = tap_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_COEFF) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_PRE;
               end
            end
         end
         S_PRE: begin
            cmd.pre_mul = 1'b1;
            state_in    = S_SAT;
         end
         S_SAT: begin
            cmd.pre_sat = 1'b1;
            band_in     = '0;
            state_in    = S_BAND;
         end
         S_BAND: begin
            if (band_ff == BAND_W'(NUM_BANDS)) begin
               state_in = S_CLIP1;
            end else if (status.band_on) begin
               cmd.acc_clear = 1'b1;
               tap_in        = TAP_B0;
               state_in      = S_MAC;
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         S_MAC: begin
            // five taps issued, then the drain taps let the last product and accumulate finish
            cmd.mac_issue = (tap_ff <= TAP_A2);
            tap_in        = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST_DRAIN) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.hist_upd = 1'b1;
            band_in      = band_ff + 1'b1;
            state_in     = S_BAND;
         end
         S_CLIP1: begin
            cmd.clip1 = 1'b1;
            state_in  = S_CLIP2;
         end
         S_CLIP2: begin
            cmd.clip2 = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         band_ff  <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

FILE: rtl/core/pbeq_datapath.sv
// ----------------------------------------------------------------------------
// pbeq_datapath
// Config registers, coefficient and history memories, MAC, soft clip, output.
// ----------------------------------------------------------------------------
module pbeq_datapath #(
   parameter int NUM_BANDS = pbeq_pkg::NUM_BANDS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic                                    csr_index,
   input  logic [pbeq_pkg::CSR_DW-1:0]             csr_wdata,
   input  logic signed [pbeq_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic [2:0]                              req_band_index,
   input  logic [2:0]                              req_coeff_index,
   input  logic signed [pbeq_pkg::COEFF_BITS-1:0]  req_coeff_value,
   input  pbeq_pkg::ctrl_cmd_type                  cmd,
   output pbeq_pkg::dp_status_type                 status,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pbeq_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);
   import pbeq_pkg::*;

   localparam int CDEPTH = NUM_BANDS * NUM_TAPS;
   localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int BIW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int ROW_W  = 4 * XW;
   localparam int PRE_W  = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int PROD_W = COEFF_BITS + XW;
   localparam int RW     = SFRAC;
   localparam int CPW    = RW + IFRAC;

   // configuration
   logic [GAIN_BITS-1:0] preamp_ff;
   logic [NUM_BANDS-1:0] band_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamp_ff      <= GAIN_BITS'(4096);
         band_active_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PREAMP:      preamp_ff      <= csr_wdata[GAIN_BITS-1:0];
            CSR_BAND_ACTIVE: band_active_ff <= csr_wdata[NUM_BANDS-1:0];
            default: ;
         endcase
      end
   end

   // coefficient memory, flat band*5+tap
   logic signed [COEFF_BITS-1:0] coef_mem [CDEPTH];
   logic signed [COEFF_BITS-1:0] rd_coef_ff;
   logic [CAW+3:0]               wr_addr_full;
   logic [CAW+BAND_W:0]          rd_addr_full;
   logic                         wr_ok;

   assign wr_addr_full = (CAW+4)'(req_band_index) * (CAW+4)'(NUM_TAPS)
                         + (CAW+4)'(req_coeff_index);
   assign wr_ok = ({2'b0, req_band_index} < 5'(NUM_BANDS))
                  && (req_coeff_index < 3'(NUM_TAPS));
   assign rd_addr_full = (CAW+BAND_W+1)'(cmd.band) * (CAW+BAND_W+1)'(NUM_TAPS)
                         + (CAW+BAND_W+1)'(cmd.tap);

   always_ff @(posedge clock) begin
      if (cmd.coef_wr && wr_ok) begin
         coef_mem[wr_addr_full[CAW-1:0]] <= req_coeff_value;
      end
      rd_coef_ff <= coef_mem[rd_addr_full[CAW-1:0]];
   end

   // history memory, one row {y2, y1, x2, x1} per band
   logic [ROW_W-1:0]     hist_mem [NUM_BANDS];
   logic [ROW_W-1:0]     hist_row_ff;
   logic [NUM_BANDS-1:0] hist_valid_ff;
   logic                 row_valid;
   logic signed [XW-1:0] h0, h1, h2, h3;

   assign row_valid = ((hist_valid_ff >> cmd.band) & NUM_BANDS'(1)) != '0;
   assign h0 = row_valid ? hist_row_ff[0*XW +: XW] : '0;
   assign h1 = row_valid ? hist_row_ff[1*XW +: XW] : '0;
   assign h2 = row_valid ? hist_row_ff[2*XW +: XW] : '0;
   assign h3 = row_valid ? hist_row_ff[3*XW +: XW] : '0;

   // sample path registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [PRE_W-1:0]       pre_ff;
   logic signed [XW-1:0]          x_ff;
   logic signed [ACC_W-1:0]       pre_ext;
   logic signed [XW-1:0]          y_new;

   assign pre_ext = ACC_W'(pre_ff);

   // MAC pipeline
   logic                    v1_ff, v2_ff;
   logic [TAP_W-1:0]        t1_ff, t2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [XW-1:0]    op;

   assign y_new   = sat_x((acc_ff + (ACC_W'(1) <<< (CFRAC - 1))) >>> CFRAC);

   always_comb begin
      case (t1_ff)
         TAP_B0:  op = x_ff;
         TAP_B1:  op = h0;
         TAP_B2:  op = h1;
         TAP_A1:  op = h2;
         TAP_A2:  op = h3;
         default: op = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         hist_valid_ff <= '0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         if (cmd.hist_upd) begin
            hist_valid_ff <= hist_valid_ff | (NUM_BANDS'(1) << cmd.band);
         end
      end
   end

   always_ff @(posedge clock) begin
      t1_ff       <= cmd.tap;
      t2_ff       <= t1_ff;
      hist_row_ff <= hist_mem[cmd.band[BIW-1:0]];
      if (cmd.capture) begin
         sample_ff <= req_sample_in;
      end
      if (cmd.pre_mul) begin
         pre_ff <= sample_ff * $signed({1'b0, preamp_ff});
      end
      if (cmd.pre_sat) begin
         x_ff <= sat_x((pre_ext + ACC_W'(2048)) >>> 12);
      end
      if (v1_ff) begin
         prod_ff <= rd_coef_ff * op;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         if (t2_ff == TAP_A1 || t2_ff == TAP_A2) begin
            acc_ff <= acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      if (cmd.hist_upd) begin
         hist_mem[cmd.band[BIW-1:0]] <= {h2, y_new, h0, x_ff};
         x_ff <= y_new;
      end
   end

   // soft clip
   logic [XW-1:0]    mag;
   logic [XW-IFRAC-1:0] idx;
   logic             big;
   logic [RW-1:0]    rom_lo, rom_hi;
   logic [RW-1:0]    base_ff, d_ff;
   logic [IFRAC-1:0] fr_ff;
   logic             neg_ff, pass_ff;
   logic [CPW-1:0]   cprod_ff;
   logic [SAMPLE_BITS-1:0] clip_mag;
   logic [SAMPLE_BITS-1:0] clip_res;

   assign mag    = x_ff[XW-1] ? XW'(-x_ff) : XW'(x_ff);
   assign idx    = mag[XW-1:IFRAC];
   assign big    = idx >= (XW-IFRAC)'(ROM_LEN - 1);
   assign rom_lo = big ? CLIP_ROM[ROM_LEN-1] : CLIP_ROM[idx[7:0]];
   assign rom_hi = big ? CLIP_ROM[ROM_LEN-1] : CLIP_ROM[9'({1'b0, idx[7:0]}) + 9'd1];

   assign clip_mag = SAMPLE_BITS'(base_ff) + SAMPLE_BITS'(cprod_ff >> IFRAC);
   assign clip_res = neg_ff ? -clip_mag : clip_mag;

   always_ff @(posedge clock) begin
      if (cmd.clip1) begin
         base_ff <= rom_lo;
         d_ff    <= rom_hi - rom_lo;
         fr_ff   <= mag[IFRAC-1:0];
         neg_ff  <= x_ff[XW-1];
         pass_ff <= mag <= KNEE;
      end
      if (cmd.clip2) begin
         cprod_ff <= CPW'(d_ff) * CPW'(fr_ff);
      end
      if (cmd.out_load) begin
         rsp_sample_out <= pass_ff ? x_ff[SAMPLE_BITS-1:0] : clip_res;
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.band_on  = ((band_active_ff >> cmd.band) & NUM_BANDS'(1)) != '0;

endmodule

FILE: dv/pbeq_checker.sv
// ----------------------------------------------------------------------------
// pbeq_checker
// Watches the request, response and register ports of the peaking biquad EQ.
// It keeps its own copy of the coefficients, band history and settings, and
// works out each equalized sample as its request beat is taken. Each response
// beat is compared in order with the oldest sample that is still due.
// ----------------------------------------------------------------------------
module pbeq_checker (
   input  logic                        clock,
   input  logic                        reset,
   pbeq_req_if                         req,
   pbeq_rsp_if                         rsp,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [pbeq_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                        drain_done,
   output int                          fails,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pbeq_pkg::*;

   localparam int  NB       = NUM_BANDS_DEF;
   localparam longint Q_MAX = (64'sd1 <<< (SFRAC + 5)) - 1;
   localparam longint Q_MIN = -Q_MAX - 1;

   longint unsigned          clip_tbl [ROM_LEN];
   longint                   coef [NB][NUM_TAPS];
   longint                   hist [NB][4];      // x1, x2, y1, y2
   logic [GAIN_BITS-1:0]     gain;
   logic [NB-1:0]            active;
   logic [SAMPLE_BITS-1:0]   due_q [$];
   logic                     drain_seen;

   // 1 - exp(-3i/32), Q0.23, Taylor series times powers of 1/e
   initial begin
      longint unsigned y, n, r, term, v, c;
      longint          sum;
      for (int i = 0; i < ROM_LEN; i++) begin
         y    = longint'(3 * i) << 27;
         n    = y >> 32;
         r    = y & 64'hFFFF_FFFF;
         term = 64'd1 << 32;
         sum  = 64'sd1 <<< 32;
         for (int k = 1; k <= 14; k++) begin
            term = ((term * r) >> 32) / longint'(k);
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = sum;
         if (v > (64'd1 << 32)) begin
            v = 64'd1 << 32;
         end
         while (n > 0) begin
            v = (v * 64'd1580030169) >> 32;
            n--;
         end
         c = ((64'd1 << 32) - v + (64'd1 << (31 - SFRAC))) >> (32 - SFRAC);
         clip_tbl[i] = (c > ((64'd1 << SFRAC) - 1)) ? ((64'd1 << SFRAC) - 1) : c;
      end
   end

   function automatic longint sat_q(longint v);
      return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
   endfunction

   function automatic longint soft_clip(longint x);
      longint m, idx, fr, d, res;
      m = (x < 0) ? -x : x;
      if (m <= longint'((95 * (64'sd1 <<< SFRAC)) / 100)) begin
         return x;
      end
      idx = m >>> IFRAC;
      if (idx >= ROM_LEN - 1) begin
         res = clip_tbl[ROM_LEN-1];
      end else begin
         fr  = m & ((64'sd1 <<< IFRAC) - 1);
         d   = longint'(clip_tbl[idx+1]) - longint'(clip_tbl[idx]);
         res = longint'(clip_tbl[idx]) + ((d * fr) >>> IFRAC);
      end
      return (x < 0) ? -res : res;
   endfunction

   // preamp, active sections in band order, soft clip; updates history
   function automatic logic [SAMPLE_BITS-1:0] equalize(logic signed [SAMPLE_BITS-1:0] s);
      longint x, acc, y;
      x = longint'(s) * longint'(gain);
      x = sat_q((x + 2048) >>> 12);
      for (int b = 0; b < NB; b++) begin
         if (active[b]) begin
            acc = coef[b][0] * x + coef[b][1] * hist[b][0] + coef[b][2] * hist[b][1]
                  - coef[b][3] * hist[b][2] - coef[b][4] * hist[b][3]
                  + (64'sd1 <<< (CFRAC - 1));
            y = sat_q(acc >>> CFRAC);
            hist[b][1] = hist[b][0];
            hist[b][0] = x;
            hist[b][3] = hist[b][2];
            hist[b][2] = y;
            x = y;
         end
      end
      return SAMPLE_BITS'(soft_clip(x));
   endfunction

   task automatic flag_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      fails++;
   endtask

   initial fails = 0;

   always @(posedge clock) begin
      logic [SAMPLE_BITS-1:0] want;
      if (reset) begin
         gain       = 16'd4096;
         active     = '0;
         drain_seen = 1'b0;
         due_q.delete();
         for (int b = 0; b < NB; b++) begin
            for (int k = 0; k < NUM_TAPS; k++) coef[b][k] = 0;
            for (int k = 0; k < 4; k++) hist[b][k] = 0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PREAMP) begin
               gain = csr_wdata;
            end else begin
               active = csr_wdata[NB-1:0];
            end
         end
         if (req.valid && req.ready) begin
            if (req.action == ACT_COEFF) begin
               if (req.band_index < NB && req.coeff_index <= TAP_A2) begin
                  coef[req.band_index][req.coeff_index] = longint'(req.coeff_value);
               end
            end else begin
               due_q = {due_q, equalize(req.sample_in)};
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (due_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected sample_out %h", rsp.sample_out));
            end else begin
               want = due_q.pop_front();
               if (rsp.sample_out !== want) begin
                  flag_mismatch($sformatf("sample_out %h, expected %h",
                                          rsp.sample_out, want));
               end
            end
         end
         if (drain_done && !drain_seen) begin
            drain_seen = 1'b1;
            if (due_q.size() != 0) begin
               flag_mismatch($sformatf("%0d samples never returned", due_q.size()));
            end
         end
      end
      pending <= due_q.size();
   end

endmodule

FILE: dv/peaking_biquad_eq_cascade_tb.sv
// ----------------------------------------------------------------------------
// peaking_biquad_eq_cascade_tb
// Drives samples and coefficient writes into the EQ cascade under several
// preamp and band settings and random idling on both sides; a checker beside
// the block predicts every output sample and compares it.
// ----------------------------------------------------------------------------
module peaking_biquad_eq_cascade_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbeq_pkg::*;

   localparam int PHASES     = 10;
   localparam int PHASE_BEATS = 152;

   localparam logic [CSR_DW-1:0] GAINS [PHASES] = '{16'd65535, 16'd0, 16'd4096,
                                                    16'd2048, 16'd12000, 16'd4096,
                                                    16'd30000, 16'd1, 16'd4096,
                                                    16'd8192};
   localparam logic [6:0]        BANDS [PHASES] = '{7'h7F, 7'h7F, 7'h7F, 7'h01, 7'h40,
                                                    7'h55, 7'h2A, 7'h7F, 7'h00, 7'h7F};

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [CSR_DW-1:0] csr_wdata;
   logic              hold_start;
   logic              drain_done;
   int                hold_cnt;
   int                tx_idle;
   int                rx_idle;
   int                fails;
   int                pending;

   pbeq_req_if req_if ();
   pbeq_rsp_if rsp_if ();

   always #5 clock = ~clock;

   peaking_biquad_eq_cascade u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pbeq_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .drain_done (drain_done),
      .fails      (fails),
      .pending    (pending)
   );

   // response side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt     <= 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_start) begin
            hold_cnt <= 400;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
         end
         rsp_if.ready <= (hold_cnt == 0) && !hold_start &&
                         ($urandom_range(0, 99) >= rx_idle);
      end
   end

   task automatic send_beat(logic act, logic [SAMPLE_BITS-1:0] s, logic [2:0] band,
                            logic [2:0] tap, logic [COEFF_BITS-1:0] value);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.sample_in   <= s;
      req_if.band_index  <= band;
      req_if.coeff_index <= tap;
      req_if.coeff_value <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
      send_beat(ACT_SAMPLE, s, 3'($urandom), 3'($urandom), $urandom);
   endtask

   task automatic send_coef(logic [2:0] band, logic [2:0] tap, logic [COEFF_BITS-1:0] v);
      send_beat(ACT_COEFF, SAMPLE_BITS'($urandom), band, tap, v);
   endtask

   task automatic write_reg(logic idx, logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // block idle: nothing due, then room for trailing coefficient writes
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
   endtask

   // mostly well-behaved sections, sometimes arbitrary words
   function automatic logic [COEFF_BITS-1:0] pick_coef(logic [2:0] tap);
      if ($urandom_range(0, 9) == 0) return $urandom;
      case (tap)
         TAP_B0:  return $urandom_range(0, 32'h2000_0000);
         TAP_A1:  return $urandom_range(0, 2 * 255013683) - 255013683;
         TAP_A2:  return $urandom_range(0, 241591910);
         default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0, 1:    return SAMPLE_BITS'($urandom);
         2:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return SAMPLE_BITS'($urandom_range(0, 1 << 21) - (1 << 20));
      endcase
   endfunction

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_PREAMP;
      csr_wdata          <= '0;
      hold_start         <= 1'b0;
      drain_done         <= 1'b0;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_SAMPLE;
      req_if.sample_in   <= '0;
      req_if.band_index  <= '0;
      req_if.coeff_index <= '0;
      req_if.coeff_value <= '0;
      tx_idle = 34;
      rx_idle = 55;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bypass path at reset settings: extremes and the clip knee
      send_sample(24'h000000);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'hFFFFFF);
      send_sample(24'h000001);
      send_sample(24'd7969177);
      send_sample(24'd7969178);
      send_sample(-24'sd7969178);
      send_sample(24'h555555);
      send_sample(24'hAAAAAA);
      // ignored writes: band out of range, tap out of range
      send_coef(3'd7, TAP_B0, 32'h7FFF_FFFF);
      send_coef(3'd0, 3'd5, 32'h8000_0000);
      send_coef(3'd0, 3'd7, 32'hFFFF_FFFF);
      send_sample(24'h123456);
      // extreme words, then overwritten below
      send_coef(3'd6, TAP_B1, 32'h7FFF_FFFF);
      send_coef(3'd6, TAP_B2, 32'h8000_0000);
      for (int b = 0; b < NUM_BANDS_DEF; b++) begin
         for (int k = 0; k <= TAP_A2; k++) begin
            send_coef(3'(b), 3'(k), pick_coef(3'(k)));
         end
      end
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            tx_idle = 55;
            rx_idle = 34;
         end else if (p == 6) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         write_reg(CSR_PREAMP, GAINS[p]);
         write_reg(CSR_BAND_ACTIVE, CSR_DW'(BANDS[p]));
         if (p == 2) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if ($urandom_range(0, 99) < 12) begin
               send_coef(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         pick_coef(3'($urandom_range(0, 4))));
            end else begin
               send_sample(pick_sample());
            end
         end
         settle();
      end

      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fails == 0) begin
         $display("peaking_biquad_eq_cascade_tb: PASS");
      end else begin
         $display("peaking_biquad_eq_cascade_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("peaking_biquad_eq_cascade_tb: FAIL");
      $finish;
   end

endmodule
